[rtl/core/qtp_pkg.sv]
// Shared types, widths and constants of the tangent-frame quaternion packer.
package qtp_pkg;

    localparam int QUAT_BITS = 16;
    localparam int U_W       = 31;
    localparam int C_W       = 36;
    localparam int LEN_W     = 32;
    localparam int OUT_TW    = ((4 * QUAT_BITS + 7) / 8) * 8;

    localparam longint DMAX_L = (longint'(1) << (QUAT_BITS - 1)) - 1;
    localparam longint BIAS_L = ((longint'(1) << 31) + DMAX_L / 2) / DMAX_L;

    // Bit-by-bit integer square root, used only to fold constants.
    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    localparam logic [63:0] FACTOR_64 =
        isqrt_c((64'd1 << 62) - 64'(BIAS_L * BIAS_L));
    localparam logic [31:0] FACTOR = FACTOR_64[31:0];
    localparam logic signed [32:0] BIAS = 33'(BIAS_L);
    localparam logic signed [32:0] DMAX = 33'(DMAX_L);

    // Shift right by 31 with rounding half away from zero.
    function automatic logic signed [65:0] rshr31(input logic signed [65:0] v);
        logic signed [65:0] half;
        half = 66'sd1 <<< 30;
        if (v >= 0) begin
            return (v + half) >>> 31;
        end
        return -((-v + half) >>> 31);
    endfunction

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               hand;
    } t_vin;

    typedef struct packed {
        logic [3:0][U_W-1:0] u;
        logic                neg_h;
    } t_side;

    typedef struct packed {
        logic [3:0][LEN_W-1:0] mag;
        logic [3:0]            uneg;
        logic                  neg_h;
    } t_mag;

endpackage

[rtl/core/tangent_frame_quaternion_pack.sv]
// Throughput: one vertex per cycle while the output buffer has room; the 32-stage
// square root and 32-stage divider each resolve one bit per stage, setting the depth.
// A two-entry output buffer lets the pipeline keep moving while a result waits.
// Reset (synchronous, active low) clears all valid bits and the output buffer.
module tangent_frame_quaternion_pack import qtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z (16 bits each)
    input  logic [95:0]       i_s_tdata,
    // handed_positive
    input  logic [0:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // quat_x, quat_y, quat_z, quat_w (QUAT_BITS each), zero padded to bytes
    output logic [OUT_TW-1:0] o_m_tdata
);

    logic en;
    t_vin vin;

    logic        f_valid;
    logic [63:0] f_len2;
    t_side       f_side;
    logic             s_valid;
    logic [LEN_W-1:0] s_len;
    t_side            s_side;
    logic  d_valid;
    t_mag  d_mag;
    logic                      b_valid;
    logic [3:0][QUAT_BITS-1:0] b_quat;

    logic [4*QUAT_BITS-1:0] r_buf [0:1];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   push, pop;

    // The whole pipeline advances whenever the output buffer has room.
    assign en         = (r_cnt != 2'd2);
    assign o_s_tready = en;

    assign vin.nx   = i_s_tdata[15:0];
    assign vin.ny   = i_s_tdata[31:16];
    assign vin.nz   = i_s_tdata[47:32];
    assign vin.tx   = i_s_tdata[63:48];
    assign vin.ty   = i_s_tdata[79:64];
    assign vin.tz   = i_s_tdata[95:80];
    assign vin.hand = i_s_tuser[0];

    qtp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_s_tvalid),
        .i_vin(vin), .o_valid(f_valid), .o_len2(f_len2), .o_side(f_side)
    );

    qtp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_valid),
        .i_len2(f_len2), .i_side(f_side),
        .o_valid(s_valid), .o_len(s_len), .o_side(s_side)
    );

    qtp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_valid),
        .i_len(s_len), .i_side(s_side), .o_valid(d_valid), .o_mag(d_mag)
    );

    qtp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_valid),
        .i_mag(d_mag), .o_valid(b_valid), .o_quat(b_quat)
    );

    assign push = en && b_valid;
    assign pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= b_quat;
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = OUT_TW'(r_buf[r_rp]);

endmodule

[rtl/core/qtp_front.sv]
// Cross product, frame matrix, largest-diagonal selection and squared length.
module qtp_front import qtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_vin        i_vin,
    output logic        o_valid,
    output logic [63:0] o_len2,
    output t_side       o_side
);

    logic [5:0] r_val;

    logic signed [31:0] r1_p [0:5];
    t_vin               r1_v;
    logic signed [32:0] r2_cx, r2_cy, r2_cz;
    t_vin               r2_v;
    logic signed [C_W-1:0] r3_f [0:3];
    logic signed [C_W-1:0] r3_d [0:2];
    logic signed [C_W-1:0] r3_s [0:2];
    logic                  r3_negh;
    logic [3:0][U_W-1:0]   r4_u;
    logic                  r4_negh;
    logic [61:0]           r5_sq [0:3];
    t_side                 r5_side;
    logic [63:0]           r6_len2;
    t_side                 r6_side;

    logic signed [C_W-1:0] n_tx, n_ty, n_tz, n_nx, n_ny, n_nz;
    logic signed [C_W-1:0] n_cx, n_cy, n_cz;
    logic signed [C_W-1:0] n_big, n_sv;
    logic signed [C_W-1:0] n_w [0:3];
    logic [1:0]            n_which;
    logic signed [U_W-1:0] n_u [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[4:0], i_valid};
        end
    end

    // Signed Q.28 matrix terms for stage three.
    always_comb begin
        n_tx = $signed({{6{r2_v.tx[15]}}, r2_v.tx, 14'd0});
        n_ty = $signed({{6{r2_v.ty[15]}}, r2_v.ty, 14'd0});
        n_tz = $signed({{6{r2_v.tz[15]}}, r2_v.tz, 14'd0});
        n_nx = $signed({{6{r2_v.nx[15]}}, r2_v.nx, 14'd0});
        n_ny = $signed({{6{r2_v.ny[15]}}, r2_v.ny, 14'd0});
        n_nz = $signed({{6{r2_v.nz[15]}}, r2_v.nz, 14'd0});
        n_cx = C_W'(r2_cx);
        n_cy = C_W'(r2_cy);
        n_cz = C_W'(r2_cz);
    end

    // Ties go to the earlier slot in the order w, x, y, z.
    always_comb begin
        n_big   = r3_f[3];
        n_which = 2'd3;
        if (r3_f[0] > n_big) begin
            n_big   = r3_f[0];
            n_which = 2'd0;
        end
        if (r3_f[1] > n_big) begin
            n_big   = r3_f[1];
            n_which = 2'd1;
        end
        if (r3_f[2] > n_big) begin
            n_big   = r3_f[2];
            n_which = 2'd2;
        end
        n_sv = n_big + (C_W'(1) <<< 28);
        case (n_which)
            2'd0: begin
                n_w[0] = n_sv;     n_w[1] = r3_s[0]; n_w[2] = r3_s[1]; n_w[3] = r3_d[0];
            end
            2'd1: begin
                n_w[0] = r3_s[0];  n_w[1] = n_sv;    n_w[2] = r3_s[2]; n_w[3] = r3_d[1];
            end
            2'd2: begin
                n_w[0] = r3_s[1];  n_w[1] = r3_s[2]; n_w[2] = n_sv;    n_w[3] = r3_d[2];
            end
            default: begin
                n_w[0] = r3_d[0];  n_w[1] = r3_d[1]; n_w[2] = r3_d[2]; n_w[3] = n_sv;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            n_u[i] = U_W'(n_w[i] >>> 3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= i_vin.ny * i_vin.tz;
            r1_p[1] <= i_vin.nz * i_vin.ty;
            r1_p[2] <= i_vin.nz * i_vin.tx;
            r1_p[3] <= i_vin.nx * i_vin.tz;
            r1_p[4] <= i_vin.nx * i_vin.ty;
            r1_p[5] <= i_vin.ny * i_vin.tx;
            r1_v    <= i_vin;

            r2_cx <= 33'(r1_p[0]) - 33'(r1_p[1]);
            r2_cy <= 33'(r1_p[2]) - 33'(r1_p[3]);
            r2_cz <= 33'(r1_p[4]) - 33'(r1_p[5]);
            r2_v  <= r1_v;

            r3_f[3] <= n_tx + n_cy + n_nz;
            r3_f[0] <= n_tx - n_cy - n_nz;
            r3_f[1] <= n_cy - n_tx - n_nz;
            r3_f[2] <= n_nz - n_tx - n_cy;
            r3_d[0] <= n_cz - n_ny;
            r3_d[1] <= n_nx - n_tz;
            r3_d[2] <= n_ty - n_cx;
            r3_s[0] <= n_ty + n_cx;
            r3_s[1] <= n_nx + n_tz;
            r3_s[2] <= n_cz + n_ny;
            r3_negh <= !r2_v.hand && (r2_cx != 0 || r2_cy != 0 || r2_cz != 0);

            for (int i = 0; i < 4; i++) begin
                r4_u[i] <= n_u[i];
            end
            r4_negh <= r3_negh;

            for (int i = 0; i < 4; i++) begin
                r5_sq[i] <= 62'($signed(r4_u[i]) * $signed(r4_u[i]));
            end
            r5_side.u     <= r4_u;
            r5_side.neg_h <= r4_negh;

            r6_len2 <= (64'(r5_sq[0]) + 64'(r5_sq[1])) + (64'(r5_sq[2]) + 64'(r5_sq[3]));
            r6_side <= r5_side;
        end
    end

    assign o_valid = r_val[5];
    assign o_len2  = r6_len2;
    assign o_side  = r6_side;

endmodule

[rtl/core/qtp_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qtp_sqrt import qtp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [63:0]      i_len2,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [LEN_W-1:0] o_len,
    output t_side            o_side
);

    logic [63:0] s_v   [0:32];
    logic [63:0] s_res [0:32];
    logic        s_val [0:32];
    t_side       s_side [0:32];

    assign s_v[0]    = i_len2;
    assign s_res[0]  = '0;
    assign s_val[0]  = i_valid;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < 32; k++) begin : g_stage
        localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
        logic [63:0] n_trial, n_v, n_res;
        logic [63:0] r_v, r_res;
        logic        r_val;
        t_side       r_side;

        always_comb begin
            n_trial = s_res[k] + BITK;
            if (s_v[k] >= n_trial) begin
                n_v   = s_v[k] - n_trial;
                n_res = (s_res[k] >> 1) + BITK;
            end else begin
                n_v   = s_v[k];
                n_res = s_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= s_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v    <= n_v;
                r_res  <= n_res;
                r_side <= s_side[k];
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_res[k+1]  = r_res;
        assign s_val[k+1]  = r_val;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_val[32];
    assign o_len   = s_res[32][LEN_W-1:0];
    assign o_side  = s_side[32];

endmodule

[rtl/core/qtp_div.sv]
// Four-lane pipelined restoring divider: |u| * 2^31 / len, one quotient bit per stage.
module qtp_div import qtp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [LEN_W-1:0] i_len,
    input  t_side            i_side,
    output logic             o_valid,
    output t_mag             o_mag
);

    logic [3:0][63:0]       s_d   [0:32];
    logic [3:0][LEN_W-1:0]  s_q   [0:32];
    logic [LEN_W-1:0]       s_len [0:32];
    logic [3:0]             s_neg [0:32];
    logic                   s_negh [0:32];
    logic                   s_val [0:32];

    logic [U_W-1:0] n_abs [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_abs[i]    = i_side.u[i][U_W-1] ? (~i_side.u[i] + 1'b1) : i_side.u[i];
            s_d[0][i]   = 64'(n_abs[i]) << 31;
            s_q[0][i]   = '0;
            s_neg[0][i] = i_side.u[i][U_W-1];
        end
    end

    assign s_len[0]  = i_len;
    assign s_negh[0] = i_side.neg_h;
    assign s_val[0]  = i_valid;

    for (genvar k = 0; k < 32; k++) begin : g_stage
        localparam int SH = 31 - k;
        logic [63:0]            n_sub;
        logic [3:0][63:0]       n_d;
        logic [3:0][LEN_W-1:0]  n_q;
        logic [3:0][63:0]       r_d;
        logic [3:0][LEN_W-1:0]  r_q;
        logic [LEN_W-1:0]       r_len;
        logic [3:0]             r_neg;
        logic                   r_negh;
        logic                   r_val;

        always_comb begin
            n_sub = 64'(s_len[k]) << SH;
            for (int i = 0; i < 4; i++) begin
                n_q[i] = s_q[k][i];
                if (s_d[k][i] >= n_sub) begin
                    n_d[i]     = s_d[k][i] - n_sub;
                    n_q[i][SH] = 1'b1;
                end else begin
                    n_d[i] = s_d[k][i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= s_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d    <= n_d;
                r_q    <= n_q;
                r_len  <= s_len[k];
                r_neg  <= s_neg[k];
                r_negh <= s_negh[k];
            end
        end

        assign s_d[k+1]    = r_d;
        assign s_q[k+1]    = r_q;
        assign s_len[k+1]  = r_len;
        assign s_neg[k+1]  = r_neg;
        assign s_negh[k+1] = r_negh;
        assign s_val[k+1]  = r_val;
    end

    assign o_valid     = s_val[32];
    assign o_mag.mag   = s_q[32];
    assign o_mag.uneg  = s_neg[32];
    assign o_mag.neg_h = s_negh[32];

endmodule

[rtl/core/qtp_back.sv]
// Sign fix, small-w bias with x/y/z rescale, handedness and snorm encode.
module qtp_back import qtp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_mag                         i_mag,
    output logic                         o_valid,
    output logic [3:0][QUAT_BITS-1:0]    o_quat
);

    logic [4:0] r_val;

    logic signed [32:0] r1_q [0:3];
    logic               r1_low, r1_negh;
    logic signed [65:0] r2_p [0:3];
    logic signed [32:0] r2_q [0:3];
    logic               r2_low, r2_negh;
    logic signed [32:0] r3_q [0:3];
    logic signed [65:0] r4_m [0:3];
    logic [3:0][QUAT_BITS-1:0] r5_quat;

    logic               n_flip;
    logic signed [32:0] n_mag [0:3];
    logic signed [32:0] n_q1 [0:3];
    logic signed [32:0] n_q3 [0:3];
    logic signed [65:0] n_r [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_en) begin
            r_val <= {r_val[3:0], i_valid};
        end
    end

    // Quotients take u's sign, all negated if w's quotient is negative and nonzero.
    always_comb begin
        n_flip = i_mag.uneg[3] && (i_mag.mag[3] != '0);
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = $signed({1'b0, i_mag.mag[i]});
            n_q1[i]  = (i_mag.uneg[i] ^ n_flip) ? -n_mag[i] : n_mag[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_r[i] = rshr31(r2_p[i]);
            if (!r2_low) begin
                n_q3[i] = r2_q[i];
            end else if (i == 3) begin
                n_q3[i] = BIAS;
            end else begin
                n_q3[i] = n_r[i][32:0];
            end
            if (r2_negh) begin
                n_q3[i] = -n_q3[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_q[i] <= n_q1[i];
            end
            r1_low  <= n_q1[3] < BIAS;
            r1_negh <= i_mag.neg_h;

            for (int i = 0; i < 4; i++) begin
                r2_p[i] <= 66'(r1_q[i]) * $signed({34'd0, FACTOR});
                r2_q[i] <= r1_q[i];
            end
            r2_low  <= r1_low;
            r2_negh <= r1_negh;

            for (int i = 0; i < 4; i++) begin
                r3_q[i] <= n_q3[i];
            end

            for (int i = 0; i < 4; i++) begin
                r4_m[i] <= 66'(r3_q[i]) * 66'(DMAX);
            end

            for (int i = 0; i < 4; i++) begin
                r5_quat[i] <= QUAT_BITS'(rshr31(r4_m[i]));
            end
        end
    end

    assign o_valid = r_val[4];
    assign o_quat  = r5_quat;

endmodule

[rtl/core/qtp_checker.sv]
// Port-level checks on the tangent-frame quaternion packer, bound to the top level.
module qtp_checker import qtp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [95:0]       i_s_tdata,
    input logic [0:0]        i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_TW-1:0] o_m_tdata
);

    // A stalled result must hold still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Back pressure on the input only arises from a full output buffer.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no pending result");

    // The w component always has magnitude of at least one step.
    a_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[4*QUAT_BITS-1:3*QUAT_BITS] != '0)
        else $error("quaternion w is zero");

endmodule

bind tangent_frame_quaternion_pack qtp_checker u_qtp_checker (.*);

[dv/tb_tangent_frame_quaternion_pack.sv]
// Self-checking testbench for the tangent-frame quaternion packer stream block.
module tb_tangent_frame_quaternion_pack;
    import qtp_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    localparam int RAND_ITEMS = 1750;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [95:0]       i_s_tdata = '0;
    logic [0:0]        i_s_tuser = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_TW-1:0] o_m_tdata;

    t_vin  vertex_q[$];
    t_quat quat_q[$];
    int    n_errors   = 0;
    int    n_sent     = 0;
    int    n_checked  = 0;
    int    idle_pct   = 0;
    int    stall_pct  = 0;
    bit    hold_off   = 1'b0;
    bit    in_fire    = 1'b0;
    int    n_in_stall = 0;

    tangent_frame_quaternion_pack u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = v;
        res = 0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint shr_floor3(input longint v);
        if (v >= 0) return v >>> 3;
        return -(((-v) + 7) >>> 3);
    endfunction

    function automatic longint shr31_round(input longint v);
        longint half;
        half = longint'(1) << 30;
        if (v >= 0) return (v + half) >>> 31;
        return -(((-v) + half) >>> 31);
    endfunction

    // Frame matrix to snorm quaternion, exact integer arithmetic throughout.
    function automatic t_quat frame_to_quat(input t_vin v);
        longint nx, ny, nz, tx, ty, tz, cx, cy, cz;
        longint fw, fx, fy, fz, big, s, one, dmax, bias, factor, r;
        longint dx, dy, dz, sxy, sxz, syz;
        longint u[4];
        longint q[4];
        longint unsigned len2, len;
        int     slot;
        t_quat  res;
        nx = longint'(v.nx); ny = longint'(v.ny); nz = longint'(v.nz);
        tx = longint'(v.tx); ty = longint'(v.ty); tz = longint'(v.tz);
        one  = longint'(1) << 31;
        dmax = (longint'(1) << (QUAT_BITS - 1)) - 1;
        cx = ny * tz - nz * ty;
        cy = nz * tx - nx * tz;
        cz = nx * ty - ny * tx;
        fw = tx * 16384 + cy + nz * 16384;
        fx = tx * 16384 - cy - nz * 16384;
        fy = cy - tx * 16384 - nz * 16384;
        fz = nz * 16384 - tx * 16384 - cy;
        // Ties go to the earlier of w, x, y, z.
        big = fw; slot = 3;
        if (fx > big) begin big = fx; slot = 0; end
        if (fy > big) begin big = fy; slot = 1; end
        if (fz > big) begin big = fz; slot = 2; end
        s = big + (longint'(1) << 28);
        dx = cz - ny * 16384; dy = nx * 16384 - tz * 16384; dz = ty * 16384 - cx;
        sxy = ty * 16384 + cx; sxz = nx * 16384 + tz * 16384; syz = cz + ny * 16384;
        case (slot)
            3: begin u[0] = dx;  u[1] = dy;  u[2] = dz;  u[3] = s;  end
            0: begin u[0] = s;   u[1] = sxy; u[2] = sxz; u[3] = dx; end
            1: begin u[0] = sxy; u[1] = s;   u[2] = syz; u[3] = dy; end
            default: begin u[0] = sxz; u[1] = syz; u[2] = s; u[3] = dz; end
        endcase
        len2 = 0;
        for (int i = 0; i < 4; i++) begin
            u[i] = shr_floor3(u[i]);
            len2 += longint'(u[i] * u[i]);
        end
        len = sqrt_floor(len2);
        if (len == 0) len = 1;
        for (int i = 0; i < 4; i++) q[i] = (u[i] * one) / longint'(len);
        if (q[3] < 0) for (int i = 0; i < 4; i++) q[i] = -q[i];
        bias = (one + dmax / 2) / dmax;
        if (q[3] < bias) begin
            factor = longint'(sqrt_floor((64'd1 << 62) - longint'(bias * bias)));
            q[3] = bias;
            for (int i = 0; i < 3; i++) q[i] = shr31_round(q[i] * factor);
        end
        if (!v.hand && (cx != 0 || cy != 0 || cz != 0))
            for (int i = 0; i < 4; i++) q[i] = -q[i];
        for (int i = 0; i < 4; i++) begin
            r = q[i];
            if (r > one) r = one;
            if (r < -one) r = -one;
            q[i] = shr31_round(r * dmax);
        end
        res.x = q[0][15:0]; res.y = q[1][15:0]; res.z = q[2][15:0]; res.w = q[3][15:0];
        return res;
    endfunction

    function automatic t_vin make_vertex(input int nx, ny, nz, tx, ty, tz, input bit h);
        t_vin v;
        v.nx = 16'(nx); v.ny = 16'(ny); v.nz = 16'(nz);
        v.tx = 16'(tx); v.ty = 16'(ty); v.tz = 16'(tz);
        v.hand = h;
        return v;
    endfunction

    function automatic real rand_unit();
        return ($urandom / 4294967296.0) * 2.0 - 1.0;
    endfunction

    // Orthonormal frame with random orientation, quantized to Q1.14.
    function automatic t_vin random_frame();
        real n[3], r[3], t[3], l;
        do begin
            for (int i = 0; i < 3; i++) n[i] = rand_unit();
            l = $sqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
        end while (l < 0.1 || l > 1.0);
        for (int i = 0; i < 3; i++) n[i] = n[i] / l;
        do begin
            for (int i = 0; i < 3; i++) r[i] = rand_unit();
            t[0] = n[1] * r[2] - n[2] * r[1];
            t[1] = n[2] * r[0] - n[0] * r[2];
            t[2] = n[0] * r[1] - n[1] * r[0];
            l = $sqrt(t[0] * t[0] + t[1] * t[1] + t[2] * t[2]);
        end while (l < 0.05);
        for (int i = 0; i < 3; i++) t[i] = t[i] / l;
        return make_vertex($rtoi($floor(n[0] * 16384.0 + 0.5)),
                           $rtoi($floor(n[1] * 16384.0 + 0.5)),
                           $rtoi($floor(n[2] * 16384.0 + 0.5)),
                           $rtoi($floor(t[0] * 16384.0 + 0.5)),
                           $rtoi($floor(t[1] * 16384.0 + 0.5)),
                           $rtoi($floor(t[2] * 16384.0 + 0.5)), 1'($urandom_range(1)));
    endfunction

    function automatic int rand_comp();
        case ($urandom_range(9))
            0: return -16384;
            1: return 16384;
            2: return 0;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    task automatic add_vertex(input t_vin v);
        vertex_q = {vertex_q, v};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: result %0d field %s got %0d expected %0d",
                 n_checked, what, got, want);
        n_errors++;
    endtask

    // Input side: a new item is chosen after the previous transfer or when idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_fire) begin
            if (vertex_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_s_tdata  <= {vertex_q[0].tz, vertex_q[0].ty, vertex_q[0].tx,
                               vertex_q[0].nz, vertex_q[0].ny, vertex_q[0].nx};
                i_s_tuser  <= vertex_q[0].hand;
                i_s_tvalid <= 1'b1;
                void'(vertex_q.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= i_rst_n && !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_vin  v;
        t_quat want;
        t_quat got;
        in_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            {v.tz, v.ty, v.tx, v.nz, v.ny, v.nx} = i_s_tdata;
            v.hand = i_s_tuser[0];
            quat_q = {quat_q, frame_to_quat(v)};
            n_sent++;
        end
        if (i_rst_n && i_s_tvalid && !o_s_tready) n_in_stall++;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[15:0];  got.y = o_m_tdata[31:16];
            got.z = o_m_tdata[47:32]; got.w = o_m_tdata[63:48];
            if (quat_q.size() == 0) begin
                report_mismatch("unexpected transfer", got.x, 0);
            end else begin
                want = quat_q.pop_front();
                if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
                if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
                if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
            end
            n_checked++;
        end
    end

    // Idling profile follows how far the stimulus has progressed.
    always @(posedge i_clk) begin
        if (n_sent < 500) begin
            idle_pct <= 0;  stall_pct <= 0;
        end else if (n_sent < 900) begin
            idle_pct <= 59; stall_pct <= 0;
        end else if (n_sent < 1300) begin
            idle_pct <= 0;  stall_pct <= 59;
        end else begin
            idle_pct <= 6;  stall_pct <= 6;
        end
    end

    // Long receiver hold-off so the pipeline fills and backpressures the input.
    initial begin
        int held;
        wait (n_sent >= 200);
        @(negedge i_clk);
        hold_off = 1'b1;
        for (held = 0; held < 300; held++) @(posedge i_clk);
        @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        // Identity frame, both handedness values.
        add_vertex(make_vertex(0, 0, 16384, 16384, 0, 0, 1'b1));
        add_vertex(make_vertex(0, 0, 16384, 16384, 0, 0, 1'b0));
        // All zero vectors give identity and never flip on handedness.
        add_vertex(make_vertex(0, 0, 0, 0, 0, 0, 1'b0));
        add_vertex(make_vertex(0, 0, 0, 0, 0, 0, 1'b1));
        // Half turn about y: w is exactly zero before the sign step.
        add_vertex(make_vertex(0, 0, -16384, -16384, 0, 0, 1'b1));
        add_vertex(make_vertex(0, 0, -16384, -16384, 0, 0, 1'b0));
        // Half turns about x and z select those slots; axis permutations pick w.
        add_vertex(make_vertex(0, 0, -16384, 16384, 0, 0, 1'b1));
        add_vertex(make_vertex(0, 0, 16384, -16384, 0, 0, 1'b0));
        add_vertex(make_vertex(0, 16384, 0, 0, 0, 16384, 1'b1));
        add_vertex(make_vertex(16384, 0, 0, 0, 16384, 0, 1'b0));
        add_vertex(make_vertex(-16384, 0, 0, 0, -16384, 0, 1'b1));
        // Extremes and non-unit or parallel vectors.
        add_vertex(make_vertex(16384, 16384, 16384, 16384, 16384, 16384, 1'b0));
        add_vertex(make_vertex(-16384, -16384, -16384, -16384, -16384, -16384, 1'b1));
        add_vertex(make_vertex(16384, -16384, 16384, -16384, 16384, -16384, 1'b0));
        add_vertex(make_vertex(-16384, 16384, -16384, 16384, -16384, 16384, 1'b1));
        add_vertex(make_vertex(0, 16384, 0, 0, 16384, 0, 1'b0));
        add_vertex(make_vertex(1, 0, 0, 0, 1, 0, 1'b0));
        add_vertex(make_vertex(11585, 0, 11585, 11585, 0, -11585, 1'b0));
        add_vertex(make_vertex(0, 11585, 11585, 16384, 0, 0, 1'b1));
        add_vertex(make_vertex(9459, 9459, 9459, 11585, -11585, 0, 1'b0));
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(99) < 70)
                add_vertex(random_frame());
            else
                add_vertex(make_vertex(rand_comp(), rand_comp(), rand_comp(),
                                       rand_comp(), rand_comp(), rand_comp(),
                                       1'($urandom_range(1))));
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (vertex_q.size() == 0 && !i_s_tvalid);
        wait (quat_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d vertices (directed axis, zero, w-zero and extreme frames, then",
                 n_sent);
        $display("random frames), %0d results checked, input stalled %0d cycles",
                 n_checked, n_in_stall);
        if (n_errors == 0 && quat_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/qtp_pkg.sv
rtl/core/qtp_front.sv
rtl/core/qtp_sqrt.sv
rtl/core/qtp_div.sv
rtl/core/qtp_back.sv
rtl/core/tangent_frame_quaternion_pack.sv
rtl/core/qtp_checker.sv
dv/tb_tangent_frame_quaternion_pack.sv
